// ===== rtl/core/pixel_rotation_forward_map_defines.svh =====
// Assertion helpers shared by the rotation pipeline.
`ifndef PIXEL_ROTATION_FORWARD_MAP_DEFINES_SVH
`define PIXEL_ROTATION_FORWARD_MAP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PRFM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rotation pipeline check failed");

// Next-cycle implication, checked out of reset.
`define PRFM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rotation pipeline check failed");

`endif

// ===== rtl/core/prfm_pkg.sv =====
package prfm_pkg;
	localparam int FRAC_BITS = 14;
	localparam int MAX_DIM   = 4096;
	localparam int FACTOR_W  = 16;
	localparam int DIM_W     = 13;
	localparam int COORD_W   = 12;
	localparam int CHAN_W    = 8;
	// dx/dy: signed difference of a 12-bit column and a 12-bit center
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = FACTOR_W + DIFF_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int Q_W       = SUM_W - FRAC_BITS;

	typedef enum logic [1:0] {
		REG_COS    = 2'd0,
		REG_SIN    = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} reg_idx_t;

	// Load strobes of the arithmetic stages.
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} stage_en_t;
endpackage

// ===== rtl/core/prfm_coord.sv =====
module prfm_coord (
	input  logic                                    clk,
	input  prfm_pkg::stage_en_t                     en,
	input  logic signed [prfm_pkg::FACTOR_W-1:0]    factor_a,
	input  logic signed [prfm_pkg::FACTOR_W-1:0]    factor_b,
	input  logic signed [prfm_pkg::DIFF_W-1:0]      term_a,
	input  logic signed [prfm_pkg::DIFF_W-1:0]      term_b,
	input  logic                                    sub_b,
	input  logic        [prfm_pkg::COORD_W-1:0]     center,
	output logic signed [prfm_pkg::Q_W-1:0]         coord_s4
);
	import prfm_pkg::*;

	localparam int PAD_W = SUM_W - COORD_W - FRAC_BITS;

	logic signed [PROD_W-1:0] prod_a_s2;
	logic signed [PROD_W-1:0] prod_b_s2;
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [SUM_W-1:0]  sum_d;
	logic signed [SUM_W-1:0]  biased;
	logic signed [SUM_W-1:0]  center_ext;

	// Center offset in the same fixed-point scale as the products.
	assign center_ext = $signed({{PAD_W{1'b0}}, center, {FRAC_BITS{1'b0}}});

	always_comb begin
		if (sub_b) begin
			sum_d = SUM_W'(prod_a_s2) - SUM_W'(prod_b_s2) + center_ext;
		end else begin
			sum_d = SUM_W'(prod_a_s2) + SUM_W'(prod_b_s2) + center_ext;
		end
	end

	// Round toward zero: bias negative sums before the arithmetic shift.
	assign biased = sum_s3[SUM_W-1]
		? sum_s3 + $signed({{(SUM_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}})
		: sum_s3;

	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			prod_a_s2 <= PROD_W'(factor_a) * PROD_W'(term_a);
			prod_b_s2 <= PROD_W'(factor_b) * PROD_W'(term_b);
		end
		if (en.ld_s3) begin
			sum_s3 <= sum_d;
		end
		if (en.ld_s4) begin
			coord_s4 <= biased[SUM_W-1:FRAC_BITS];
		end
	end
endmodule

// ===== rtl/core/pixel_rotation_forward_map.sv =====
// Forward-mapping nearest-neighbor rotation of a pixel stream. Each request
// carries one source pixel (column, row, three 8-bit channels); the block
// rotates its coordinates about the frame center (width/2, height/2) with the
// programmed Q2.14 cosine and sine factors, truncates toward zero, and returns
// the destination column and row with an in-bounds flag. Out-of-frame pixels
// come back with in_bounds low and zero coordinates; channels always pass
// through. Frame sizes above 4096 are clipped to 4096 for the bounds check.
// The pipeline is five register stages deep (difference, multiply, sum,
// truncate, bounds check), and one pixel is taken every clock unless the
// output stalls with all stages full. Each stage keeps its own valid bit and
// fills while the output is stalled, so in_ready drops only once all five
// stages hold data. Program the registers only while no request is in
// flight.
`include "pixel_rotation_forward_map_defines.svh"

module pixel_rotation_forward_map (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wen,
	input  prfm_pkg::reg_idx_t                    cfg_idx,
	input  logic [prfm_pkg::FACTOR_W-1:0]         cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [prfm_pkg::COORD_W-1:0]          src_col,
	input  logic [prfm_pkg::COORD_W-1:0]          src_row,
	input  logic [prfm_pkg::CHAN_W-1:0]           channel_0,
	input  logic [prfm_pkg::CHAN_W-1:0]           channel_1,
	input  logic [prfm_pkg::CHAN_W-1:0]           channel_2,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [prfm_pkg::COORD_W-1:0]          dest_col,
	output logic [prfm_pkg::COORD_W-1:0]          dest_row,
	output logic                                  in_bounds,
	output logic [prfm_pkg::CHAN_W-1:0]           out_channel_0,
	output logic [prfm_pkg::CHAN_W-1:0]           out_channel_1,
	output logic [prfm_pkg::CHAN_W-1:0]           out_channel_2
);
	import prfm_pkg::*;

	localparam int NSTG = 5;
	localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_DIM);

	// Configuration registers.
	logic signed [FACTOR_W-1:0] cos_q;
	logic signed [FACTOR_W-1:0] sin_q;
	logic [DIM_W-1:0]           width_q;
	logic [DIM_W-1:0]           height_q;

	// Pipeline control: valid per stage, load when the stage is empty or drains.
	logic [NSTG-1:0] vld;
	logic [NSTG:0]   ld;
	stage_en_t       en;

	// Stage 1: offsets from the center.
	logic signed [DIFF_W-1:0] dx_s1;
	logic signed [DIFF_W-1:0] dy_s1;

	// Channels ride along with the coordinates.
	logic [CHAN_W-1:0] ch0_s1, ch0_s2, ch0_s3, ch0_s4;
	logic [CHAN_W-1:0] ch1_s1, ch1_s2, ch1_s3, ch1_s4;
	logic [CHAN_W-1:0] ch2_s1, ch2_s2, ch2_s3, ch2_s4;

	logic [COORD_W-1:0] cx;
	logic [COORD_W-1:0] cy;
	logic [DIM_W-1:0]   w_lim;
	logic [DIM_W-1:0]   h_lim;

	logic signed [Q_W-1:0] qx_s4;
	logic signed [Q_W-1:0] qy_s4;
	logic                  ok;

	// Output stage (stage 5).
	logic [COORD_W-1:0] dest_col_s5;
	logic [COORD_W-1:0] dest_row_s5;
	logic               in_bounds_s5;
	logic [CHAN_W-1:0]  ch0_s5;
	logic [CHAN_W-1:0]  ch1_s5;
	logic [CHAN_W-1:0]  ch2_s5;

	// Register writes; width and height keep their low 13 bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q    <= FACTOR_W'(1 << FRAC_BITS);
			sin_q    <= '0;
			width_q  <= DIM_W'(640);
			height_q <= DIM_W'(480);
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_COS:    cos_q    <= cfg_wdata;
				REG_SIN:    sin_q    <= cfg_wdata;
				REG_WIDTH:  width_q  <= cfg_wdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_wdata[DIM_W-1:0];
			endcase
		end
	end

	assign cx = width_q[DIM_W-1:1];
	assign cy = height_q[DIM_W-1:1];
	// Clip oversized frames for the bounds check.
	assign w_lim = (width_q > DIM_LIMIT) ? DIM_LIMIT : width_q;
	assign h_lim = (height_q > DIM_LIMIT) ? DIM_LIMIT : height_q;

	// Ready ripples back from the output: a stage loads when it is empty or
	// when the stage after it loads in the same cycle.
	always_comb begin
		ld[NSTG] = out_ready;
		for (int k = NSTG - 1; k >= 0; k--) begin
			ld[k] = !vld[k] || ld[k+1];
		end
	end

	assign in_ready = ld[0];
	assign en.ld_s2 = ld[1];
	assign en.ld_s3 = ld[2];
	assign en.ld_s4 = ld[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (ld[0]) begin
				vld[0] <= in_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (ld[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	// Stage 1: take the request and form the signed center offsets.
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			dx_s1  <= $signed({1'b0, src_col}) - $signed({1'b0, cx});
			dy_s1  <= $signed({1'b0, src_row}) - $signed({1'b0, cy});
			ch0_s1 <= channel_0;
			ch1_s1 <= channel_1;
			ch2_s1 <= channel_2;
		end
	end

	// Stages 2 to 4 for X: cos*dx - sin*dy + cx, truncated toward zero.
	prfm_coord u_coord_x (
		.clk      (clk),
		.en       (en),
		.factor_a (cos_q),
		.factor_b (sin_q),
		.term_a   (dx_s1),
		.term_b   (dy_s1),
		.sub_b    (1'b1),
		.center   (cx),
		.coord_s4 (qx_s4)
	);

	// Stages 2 to 4 for Y: sin*dx + cos*dy + cy, truncated toward zero.
	prfm_coord u_coord_y (
		.clk      (clk),
		.en       (en),
		.factor_a (sin_q),
		.factor_b (cos_q),
		.term_a   (dx_s1),
		.term_b   (dy_s1),
		.sub_b    (1'b0),
		.center   (cy),
		.coord_s4 (qy_s4)
	);

	// Advance the channels alongside the arithmetic stages.
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			ch0_s2 <= ch0_s1;
			ch1_s2 <= ch1_s1;
			ch2_s2 <= ch2_s1;
		end
		if (ld[2]) begin
			ch0_s3 <= ch0_s2;
			ch1_s3 <= ch1_s2;
			ch2_s3 <= ch2_s2;
		end
		if (ld[3]) begin
			ch0_s4 <= ch0_s3;
			ch1_s4 <= ch1_s3;
			ch2_s4 <= ch2_s3;
		end
	end

	// Stage 5: bounds check; a dropped pixel reports zero coordinates.
	assign ok = !qx_s4[Q_W-1] && (qx_s4[Q_W-2:0] < (Q_W-1)'(w_lim))
		&& !qy_s4[Q_W-1] && (qy_s4[Q_W-2:0] < (Q_W-1)'(h_lim));

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			dest_col_s5  <= ok ? qx_s4[COORD_W-1:0] : '0;
			dest_row_s5  <= ok ? qy_s4[COORD_W-1:0] : '0;
			in_bounds_s5 <= ok;
			ch0_s5       <= ch0_s4;
			ch1_s5       <= ch1_s4;
			ch2_s5       <= ch2_s4;
		end
	end

	assign out_valid     = vld[NSTG-1];
	assign dest_col      = dest_col_s5;
	assign dest_row      = dest_row_s5;
	assign in_bounds     = in_bounds_s5;
	assign out_channel_0 = ch0_s5;
	assign out_channel_1 = ch1_s5;
	assign out_channel_2 = ch2_s5;

	// A dropped pixel never carries coordinates.
	`PRFM_ASSERT_NOW(a_drop_zero, out_valid && !in_bounds, dest_col == '0 && dest_row == '0)
	// An accepted pixel lands in the first stage.
	`PRFM_ASSERT_NEXT(a_accept_s1, in_valid && in_ready, vld[0])
	// Back-pressure reaches the input only when every stage is full.
	`PRFM_ASSERT_NOW(a_stall_full, !in_ready, vld == {NSTG{1'b1}} && !out_ready)
	// A reported destination lies inside the clipped frame.
	`PRFM_ASSERT_NOW(a_col_in_frame, out_valid && in_bounds, ({1'b0, dest_col} < w_lim))
	`PRFM_ASSERT_NOW(a_row_in_frame, out_valid && in_bounds, ({1'b0, dest_row} < h_lim))
endmodule
